[rtl/gcp_pkg.sv]
package gcp_pkg;

   // word widths
   localparam int DATA_W    = 32;
   localparam int EPS_W     = 31;
   localparam int JAC_W     = 48;
   localparam int T_W       = 49;
   localparam int FRAC_SH   = 32;
   localparam int NUM_SIGMA = 9;
   localparam int NUM_T     = 6;
   localparam int NUM_OUT   = 4;

   // divider
   localparam int DIV_W     = 64;
   localparam int DIV_DEN_W = 31;
   localparam int DIV_STEPS = 64;
   localparam int DIV_LANES = 4;
   localparam int LANE_FX   = 0;
   localparam int LANE_FY   = 1;
   localparam int LANE_PX   = 2;
   localparam int LANE_PY   = 3;

   // multiplier chunking
   localparam int MUL_CHUNK = 24;

   // rounding and saturation constants
   localparam logic [JAC_W-1:0] JAC_MAX  = 48'h7FFF_FFFF_FFFF;
   localparam logic [DIV_W-1:0] HALF_LSB = 64'h0000_0000_8000_0000;

   // register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIAG_EPS = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] pos_z;
      logic signed [DATA_W-1:0] sigma_00;
      logic signed [DATA_W-1:0] sigma_01;
      logic signed [DATA_W-1:0] sigma_02;
      logic signed [DATA_W-1:0] sigma_10;
      logic signed [DATA_W-1:0] sigma_11;
      logic signed [DATA_W-1:0] sigma_12;
      logic signed [DATA_W-1:0] sigma_20;
      logic signed [DATA_W-1:0] sigma_21;
      logic signed [DATA_W-1:0] sigma_22;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] screen_cov_00;
      logic signed [DATA_W-1:0] screen_cov_01;
      logic signed [DATA_W-1:0] screen_cov_10;
      logic signed [DATA_W-1:0] screen_cov_11;
      logic                     bad_depth;
      logic                     overflow;
   } rsp_word_type;

endpackage

[rtl/gcp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
module gcp_div (
   input  logic                                                clock,
   input  logic [gcp_pkg::DIV_LANES-1:0][gcp_pkg::DIV_W-1:0]   dividend,
   input  logic [gcp_pkg::DIV_DEN_W-1:0]                       divisor,
   output logic [gcp_pkg::DIV_LANES-1:0][gcp_pkg::DIV_W-1:0]   quotient
);
   import gcp_pkg::*;

   logic [DIV_DEN_W-1:0] den_ff  [DIV_STEPS];
   logic [DIV_DEN_W-1:0] rem_ff  [DIV_STEPS][DIV_LANES];
   logic [DIV_W-1:0]     work_ff [DIV_STEPS][DIV_LANES];

   // work register: remaining dividend bits shift out the top, quotient bits in the bottom
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      logic [DIV_DEN_W-1:0] den_prev;

      if (s == 0) begin : g_first
         assign den_prev = divisor;
      end else begin : g_next
         assign den_prev = den_ff[s-1];
      end

      always_ff @(posedge clock) begin
         den_ff[s] <= den_prev;
      end

      for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
         logic [DIV_DEN_W-1:0] rem_prev;
         logic [DIV_W-1:0]     work_prev;
         logic [DIV_DEN_W:0]   trial;
         logic [DIV_DEN_W:0]   diff;
         logic                 ge;
         logic [DIV_DEN_W-1:0] rem_in;
         logic [DIV_W-1:0]     work_in;

         if (s == 0) begin : g_first
            assign rem_prev  = '0;
            assign work_prev = dividend[l];
         end else begin : g_next
            assign rem_prev  = rem_ff[s-1][l];
            assign work_prev = work_ff[s-1][l];
         end

         always_comb begin
            trial   = {rem_prev, work_prev[DIV_W-1]};
            diff    = trial - {1'b0, den_prev};
            ge      = (trial >= {1'b0, den_prev});
            rem_in  = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            work_in = {work_prev[DIV_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            rem_ff[s][l]  <= rem_in;
            work_ff[s][l] <= work_in;
         end
      end
   end

   for (genvar l = 0; l < DIV_LANES; l++) begin : g_out
      assign quotient[l] = work_ff[DIV_STEPS-1][l];
   end

endmodule

[rtl/gcp_mul.sv]
// Two-stage signed multiplier: b cut into chunks, partial products registered, then summed.
module gcp_mul #(
   parameter int A_W = 48,
   parameter int B_W = 32
) (
   input  logic                        clock,
   input  logic signed [A_W-1:0]       a,
   input  logic signed [B_W-1:0]       b,
   output logic signed [A_W+B_W-1:0]   p
);
   import gcp_pkg::*;

   localparam int NCH   = (B_W + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int BP    = NCH * MUL_CHUNK;
   localparam int PP_W  = A_W + MUL_CHUNK + 1;
   localparam int SUM_W = A_W + BP;

   logic signed [BP-1:0]          b_ext;
   logic signed [PP_W-1:0]        pp_in [NCH];
   logic signed [PP_W-1:0]        pp_ff [NCH];
   logic signed [SUM_W-1:0]       sum_in;
   logic signed [A_W+B_W-1:0]     p_ff;

   // partial products: lower chunks unsigned, top chunk carries the sign
   always_comb begin
      b_ext = BP'(b);
      for (int k = 0; k < NCH; k++) begin
         if (k == NCH - 1) begin
            pp_in[k] = PP_W'(a * $signed(b_ext[k*MUL_CHUNK +: MUL_CHUNK]));
         end else begin
            pp_in[k] = PP_W'(a * $signed({1'b0, b_ext[k*MUL_CHUNK +: MUL_CHUNK]}));
         end
      end
   end

   // weighted sum of the partial products
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < NCH; k++) begin
         sum_in = sum_in + (SUM_W'(pp_ff[k]) <<< (k * MUL_CHUNK));
      end
   end

   always_ff @(posedge clock) begin
      pp_ff <= pp_in;
      p_ff  <= sum_in[A_W+B_W-1:0];
   end

   assign p = p_ff;

endmodule

[rtl/gaussian_cov_projection.sv]
// Throughput: one word per cycle, busy stays low; the 64-stage divider sets the depth.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous) empties the pipeline and restores focal_x = focal_y = 1.0,
// diag_epsilon = 0.
module gaussian_cov_projection (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  gcp_pkg::req_word_type               req_data,
   output logic                                rsp_valid,
   output gcp_pkg::rsp_word_type               rsp_data,
   input  logic                                csr_we,
   input  logic [gcp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gcp_pkg::DATA_W-1:0]          csr_data
);
   import gcp_pkg::*;

   localparam int CTL_DLY = 74;
   localparam int SIG_DLY = 68;
   localparam int B_PW    = JAC_W + DIV_W + 1;
   localparam int T_PW    = JAC_W + DATA_W;
   localparam int C_PW    = T_W + JAC_W;
   localparam int W_W     = C_PW + 1 - FRAC_SH;
   localparam int V_W     = W_W + 1;

   typedef struct packed {
      logic valid;
      logic bad;
      logic x_neg;
      logic y_neg;
   } ctl_type;

   typedef struct packed {
      logic signed [JAC_W-1:0] a;
      logic signed [JAC_W-1:0] b;
      logic signed [JAC_W-1:0] c;
      logic signed [JAC_W-1:0] d;
      logic                    ovf;
   } jac_type;

   // configuration registers
   logic [DATA_W-1:0] focal_x_ff, focal_y_ff;
   logic [EPS_W-1:0]  eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff <= 32'h0001_0000;
         focal_y_ff <= 32'h0001_0000;
         eps_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FOCAL_X:  focal_x_ff <= csr_data;
            CSR_FOCAL_Y:  focal_y_ff <= csr_data;
            CSR_DIAG_EPS: eps_ff     <= csr_data[EPS_W-1:0];
            default:      ;
         endcase
      end
   end

   assign busy = 1'b0;

   // input register
   logic          in_valid_ff;
   req_word_type  in_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
      in_data_ff <= req_data;
   end

   // dividends: focal lengths and |x|, |y|, each scaled by 2^32 plus half the depth
   logic [DATA_W-1:0]                      x_mag, y_mag;
   logic [DIV_W-1:0]                       half_z;
   logic [DIV_LANES-1:0][DIV_W-1:0]        div_num;
   logic [DIV_LANES-1:0][DIV_W-1:0]        div_q;
   logic                                   bad_in;

   always_comb begin
      x_mag  = in_data_ff.pos_x[DATA_W-1] ? DATA_W'(-in_data_ff.pos_x)
                                          : DATA_W'(in_data_ff.pos_x);
      y_mag  = in_data_ff.pos_y[DATA_W-1] ? DATA_W'(-in_data_ff.pos_y)
                                          : DATA_W'(in_data_ff.pos_y);
      half_z = DIV_W'(in_data_ff.pos_z[DATA_W-2:1]);
      div_num[LANE_FX] = {focal_x_ff, 32'h0} + half_z;
      div_num[LANE_FY] = {focal_y_ff, 32'h0} + half_z;
      div_num[LANE_PX] = {x_mag, 32'h0} + half_z;
      div_num[LANE_PY] = {y_mag, 32'h0} + half_z;
      bad_in = in_data_ff.pos_z[DATA_W-1] | (in_data_ff.pos_z == '0);
   end

   gcp_div u_div (
      .clock    (clock),
      .dividend (div_num),
      .divisor  (in_data_ff.pos_z[DIV_DEN_W-1:0]),
      .quotient (div_q)
   );

   // control and sigma delay lines
   ctl_type                           ctl_ff [CTL_DLY];
   logic [NUM_SIGMA-1:0][DATA_W-1:0]  sig_ff [SIG_DLY];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CTL_DLY; k++) begin
            ctl_ff[k] <= '0;
         end
      end else begin
         ctl_ff[0] <= '{valid: in_valid_ff, bad: bad_in,
                        x_neg: in_data_ff.pos_x[DATA_W-1], y_neg: in_data_ff.pos_y[DATA_W-1]};
         for (int k = 1; k < CTL_DLY; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
      sig_ff[0] <= {in_data_ff.sigma_22, in_data_ff.sigma_21, in_data_ff.sigma_20,
                    in_data_ff.sigma_12, in_data_ff.sigma_11, in_data_ff.sigma_10,
                    in_data_ff.sigma_02, in_data_ff.sigma_01, in_data_ff.sigma_00};
      for (int k = 1; k < SIG_DLY; k++) begin
         sig_ff[k] <= sig_ff[k-1];
      end
   end

   // diagonal Jacobian terms, saturated
   logic [JAC_W-1:0] a_in, c_in;
   logic             a_sat, c_sat;
   logic [JAC_W-1:0] j1_a_ff, j1_c_ff;
   logic [DIV_W-1:0] j1_rx_ff, j1_ry_ff;
   logic             j1_ovf_ff;

   always_comb begin
      a_sat = |div_q[LANE_FX][DIV_W-1:JAC_W-1];
      c_sat = |div_q[LANE_FY][DIV_W-1:JAC_W-1];
      a_in  = a_sat ? JAC_MAX : div_q[LANE_FX][JAC_W-1:0];
      c_in  = c_sat ? JAC_MAX : div_q[LANE_FY][JAC_W-1:0];
   end

   always_ff @(posedge clock) begin
      j1_a_ff   <= a_in;
      j1_c_ff   <= c_in;
      j1_rx_ff  <= div_q[LANE_PX];
      j1_ry_ff  <= div_q[LANE_PY];
      j1_ovf_ff <= a_sat | c_sat;
   end

   // cross terms: diagonal times depth ratio
   logic signed [B_PW-1:0] pb, pd;

   gcp_mul #(.A_W(JAC_W), .B_W(DIV_W + 1)) u_mul_b (
      .clock (clock),
      .a     ($signed(j1_a_ff)),
      .b     ($signed({1'b0, j1_rx_ff})),
      .p     (pb)
   );

   gcp_mul #(.A_W(JAC_W), .B_W(DIV_W + 1)) u_mul_d (
      .clock (clock),
      .a     ($signed(j1_c_ff)),
      .b     ($signed({1'b0, j1_ry_ff})),
      .p     (pd)
   );

   // hold a, c while the cross products are formed
   jac_type ac_ff [2];

   always_ff @(posedge clock) begin
      ac_ff[0] <= '{a: j1_a_ff, b: '0, c: j1_c_ff, d: '0, ovf: j1_ovf_ff};
      ac_ff[1] <= ac_ff[0];
   end

   // round, saturate and sign the cross terms
   logic [B_PW-1:0]            vb, vd;
   logic [B_PW-FRAC_SH-1:0]    mb, md;
   logic                       b_sat, d_sat;
   logic [JAC_W-1:0]           b_mag, d_mag;
   jac_type                    bd_in, bd_ff;

   always_comb begin
      vb    = B_PW'(pb) + B_PW'(HALF_LSB);
      vd    = B_PW'(pd) + B_PW'(HALF_LSB);
      mb    = vb[B_PW-1:FRAC_SH];
      md    = vd[B_PW-1:FRAC_SH];
      b_sat = |mb[B_PW-FRAC_SH-1:JAC_W-1];
      d_sat = |md[B_PW-FRAC_SH-1:JAC_W-1];
      b_mag = b_sat ? JAC_MAX : {1'b0, mb[JAC_W-2:0]};
      d_mag = d_sat ? JAC_MAX : {1'b0, md[JAC_W-2:0]};
      bd_in     = ac_ff[1];
      bd_in.b   = ctl_ff[66].x_neg ? $signed(b_mag) : -$signed(b_mag);
      bd_in.d   = ctl_ff[66].y_neg ? $signed(d_mag) : -$signed(d_mag);
      bd_in.ovf = ac_ff[1].ovf | b_sat | d_sat;
   end

   always_ff @(posedge clock) begin
      bd_ff <= bd_in;
   end

   // T = J * Sigma: twelve products, pair i forms T entry i
   logic signed [JAC_W-1:0]  tm_j [2*NUM_T];
   logic signed [DATA_W-1:0] tm_s [2*NUM_T];
   logic signed [T_PW-1:0]   tm_p [2*NUM_T];

   always_comb begin
      for (int i = 0; i < NUM_T; i++) begin
         if (i < 3) begin
            tm_j[2*i]   = bd_ff.a;
            tm_j[2*i+1] = bd_ff.b;
            tm_s[2*i+1] = $signed(sig_ff[SIG_DLY-1][i+6]);
         end else begin
            tm_j[2*i]   = bd_ff.c;
            tm_j[2*i+1] = bd_ff.d;
            tm_s[2*i+1] = $signed(sig_ff[SIG_DLY-1][i+3]);
         end
         tm_s[2*i] = $signed(sig_ff[SIG_DLY-1][i]);
      end
   end

   for (genvar i = 0; i < 2*NUM_T; i++) begin : g_tmul
      gcp_mul #(.A_W(JAC_W), .B_W(DATA_W)) u_mul (
         .clock (clock),
         .a     (tm_j[i]),
         .b     (tm_s[i]),
         .p     (tm_p[i])
      );
   end

   // hold J for the second product
   jac_type jd_ff [3];

   always_ff @(posedge clock) begin
      jd_ff[0] <= bd_ff;
      jd_ff[1] <= jd_ff[0];
      jd_ff[2] <= jd_ff[1];
   end

   // sum pairs, round to Q16.16
   logic signed [T_PW:0]    ts [NUM_T];
   logic signed [T_W-1:0]   t_ff [NUM_T];

   always_comb begin
      for (int i = 0; i < NUM_T; i++) begin
         ts[i] = (T_PW+1)'(tm_p[2*i]) + (T_PW+1)'(tm_p[2*i+1]) + (T_PW+1)'(HALF_LSB);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_T; i++) begin
         t_ff[i] <= ts[i][T_PW:FRAC_SH];
      end
   end

   // C = T * J^T: eight products, pair k forms output entry k
   logic signed [T_W-1:0]   cm_t [2*NUM_OUT];
   logic signed [JAC_W-1:0] cm_j [2*NUM_OUT];
   logic signed [C_PW-1:0]  cm_p [2*NUM_OUT];

   always_comb begin
      cm_t[0] = t_ff[0]; cm_j[0] = jd_ff[2].a;
      cm_t[1] = t_ff[2]; cm_j[1] = jd_ff[2].b;
      cm_t[2] = t_ff[1]; cm_j[2] = jd_ff[2].c;
      cm_t[3] = t_ff[2]; cm_j[3] = jd_ff[2].d;
      cm_t[4] = t_ff[3]; cm_j[4] = jd_ff[2].a;
      cm_t[5] = t_ff[5]; cm_j[5] = jd_ff[2].b;
      cm_t[6] = t_ff[4]; cm_j[6] = jd_ff[2].c;
      cm_t[7] = t_ff[5]; cm_j[7] = jd_ff[2].d;
   end

   for (genvar i = 0; i < 2*NUM_OUT; i++) begin : g_cmul
      gcp_mul #(.A_W(T_W), .B_W(JAC_W)) u_mul (
         .clock (clock),
         .a     (cm_t[i]),
         .b     (cm_j[i]),
         .p     (cm_p[i])
      );
   end

   // overflow flag follows the C products
   logic ovf_ff [3];

   always_ff @(posedge clock) begin
      ovf_ff[0] <= jd_ff[2].ovf;
      ovf_ff[1] <= ovf_ff[0];
      ovf_ff[2] <= ovf_ff[1];
   end

   // sum pairs and round
   logic signed [C_PW:0]   cs [NUM_OUT];
   logic signed [W_W-1:0]  w_ff [NUM_OUT];

   always_comb begin
      for (int k = 0; k < NUM_OUT; k++) begin
         cs[k] = (C_PW+1)'(cm_p[2*k]) + (C_PW+1)'(cm_p[2*k+1]) + (C_PW+1)'(HALF_LSB);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_OUT; k++) begin
         w_ff[k] <= cs[k][C_PW:FRAC_SH];
      end
   end

   // epsilon on the diagonal, saturate to 32 bits
   logic [V_W-1:0]          v [NUM_OUT];
   logic [DATA_W-1:0]       r [NUM_OUT];
   logic [NUM_OUT-1:0]      r_sat;
   ctl_type                 ctl_out;
   rsp_word_type            rsp_in;
   rsp_word_type            rsp_data_ff;
   logic                    rsp_valid_ff;

   always_comb begin
      for (int k = 0; k < NUM_OUT; k++) begin
         v[k] = V_W'(w_ff[k]);
         if (k == 0 || k == NUM_OUT - 1) begin
            v[k] = v[k] + V_W'(eps_ff);
         end
         r_sat[k] = !((v[k][V_W-1:DATA_W-1] == '0) || (v[k][V_W-1:DATA_W-1] == '1));
         if (r_sat[k]) begin
            r[k] = v[k][V_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            r[k] = v[k][DATA_W-1:0];
         end
      end
      ctl_out = ctl_ff[CTL_DLY-1];
      if (ctl_out.bad) begin
         rsp_in = '{screen_cov_00: '0, screen_cov_01: '0, screen_cov_10: '0,
                    screen_cov_11: '0, bad_depth: 1'b1, overflow: 1'b0};
      end else begin
         rsp_in = '{screen_cov_00: r[0], screen_cov_01: r[1], screen_cov_10: r[2],
                    screen_cov_11: r[3], bad_depth: 1'b0,
                    overflow: ovf_ff[2] | (|r_sat)};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_out.valid;
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
